FILE: hdl/gradient_color_ramp_builder_core_defines.svh
// Assertion macros for the gradient colour ramp builder.
`ifndef GRADIENT_COLOR_RAMP_BUILDER_CORE_DEFINES_SVH
`define GRADIENT_COLOR_RAMP_BUILDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GCRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gcrb assertion failed");
`define GCRB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gcrb assertion failed");
`else
`define GCRB_ASSERT(lbl, prop)
`define GCRB_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: hdl/gcrb_pkg.sv
// Types, constants and helper functions of the gradient colour ramp builder.
`default_nettype none
package gcrb_pkg;

  localparam int RAMP_WIDTH = 1024;
  localparam int MAX_STOPS  = 16;
  localparam int RAMP_IW    = $clog2(RAMP_WIDTH);
  localparam int RAMP_CW    = RAMP_IW + 1;
  localparam int STOP_IW    = $clog2(MAX_STOPS);
  localparam int STOP_CW    = STOP_IW + 1;
  localparam int POS_W      = 17;
  localparam int POS_SHIFT  = 16 - RAMP_IW;
  localparam int FRAC_W     = 16;
  localparam int DIV_W      = 8 + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int ACC_W      = DIV_W + 2;
  localparam int COL_W      = 32;
  localparam int PIX_IN_W   = 10;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_RB_RD,
    S_RB_SEG,
    S_RB_DIV,
    S_RB_PIX,
    S_RB_NEXT,
    S_RB_FILL,
    S_RD_ISSUE,
    S_RD_DATA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] offset;
    logic [COL_W-1:0] color;
  } stop_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [DIV_W-1:0]   mag;
    logic [RAMP_CW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] y;
    x = c * a;
    y = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return y[15:8];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_W-1:0] b;
    b = acc[ACC_W-1:FRAC_W];
    if (acc[ACC_W-1]) return 8'd0;
    if (b > 255) return 8'hFF;
    return b[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/gcrb_if.sv
// Command and result channel interfaces.
`default_nettype none
interface gcrb_in_if import gcrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [POS_W-1:0]    stop_position;
  logic [7:0]          stop_red;
  logic [7:0]          stop_green;
  logic [7:0]          stop_blue;
  logic [7:0]          stop_alpha;
  logic [PIX_IN_W-1:0] pixel_index;
  modport source (output valid, command, stop_position, stop_red, stop_green, stop_blue,
                  stop_alpha, pixel_index, input ready);
  modport sink (input valid, command, stop_position, stop_red, stop_green, stop_blue,
                stop_alpha, pixel_index, output ready);
endinterface

interface gcrb_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source (output valid, status, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, status, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/gradient_color_ramp_builder_core.sv
// Top level of the gradient colour ramp builder.
//
//  channel | dir | handshake   | beat
//  in_i    | in  | valid/ready | command, stop fields, pixel index
//  out_o   | out | valid/ready | status and premultiplied RGBA
//
// Clear, unknown commands and an add to a full table go straight to the result; other adds
// first move stops up one place per step (one read and one write of the stop memory).
// A read of a valid ramp reads the ramp memory; a read of an invalid ramp first rebuilds
// it stop by stop, running the dividers for each segment with pixels (1024 in all).
// Reset empties the stop table and marks the ramp invalid; no memory clearing.
// A result waiting on out_o stalls only the next command at its final step (S_DONE).
`include "gradient_color_ramp_builder_core_defines.svh"
`default_nettype none
module gradient_color_ramp_builder_core import gcrb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  gcrb_in_if.sink   in_i,
  gcrb_out_if.source out_o
);

  state_e               state_q, state_d;
  logic [STOP_CW-1:0]   count_q, count_d;
  logic                 valid_q, valid_d;
  stop_t                new_q, new_d;
  logic [STOP_IW-1:0]   j_q, j_d;
  logic [STOP_IW-1:0]   s_q, s_d;
  logic [RAMP_CW-1:0]   idx_q, idx_d;
  logic [RAMP_CW-1:0]   sp_q, sp_d;
  logic [COL_W-1:0]     cur_q, cur_d;
  logic [COL_W-1:0]     nxt_q, nxt_d;
  logic signed [ACC_W-1:0] acc_q [4];
  logic signed [ACC_W-1:0] acc_d [4];
  logic signed [ACC_W-1:0] inc_q [4];
  logic signed [ACC_W-1:0] inc_d [4];
  logic [PIX_IN_W-1:0]  pix_q, pix_d;
  logic                 res_status_q, res_status_d;
  logic [COL_W-1:0]     res_color_q, res_color_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q, out_status_d;
  logic [COL_W-1:0]     out_color_q, out_color_d;

  stop_t                stop_mem [MAX_STOPS];
  stop_t                stop_rd_q;
  logic                 stop_we;
  logic [STOP_IW-1:0]   stop_wa, stop_ra;
  stop_t                stop_wd;

  logic [COL_W-1:0]     ramp_mem [RAMP_WIDTH];
  logic [COL_W-1:0]     ramp_rd_q;
  logic                 ramp_we;
  logic [RAMP_IW-1:0]   ramp_wa, ramp_ra;
  logic [COL_W-1:0]     ramp_wd;

  div_req_t             div_req [4];
  div_rsp_t             div_rsp [4];

  logic [RAMP_CW-1:0]   seg_sp;
  logic [COL_W-1:0]     seg_cur;
  logic signed [8:0]    seg_d [4];
  logic [7:0]           a_in;

  for (genvar k = 0; k < 4; k++) begin : g_div
    gcrb_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (div_req[k]),
      .rsp_o  (div_rsp[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (stop_we) stop_mem[stop_wa] <= stop_wd;
    stop_rd_q <= stop_mem[stop_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ramp_we) ramp_mem[ramp_wa] <= ramp_wd;
    ramp_rd_q <= ramp_mem[ramp_ra];
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign a_in       = in_i.stop_alpha;

  always_comb begin
    seg_sp = (stop_rd_q.offset[POS_W-1:POS_SHIFT] > RAMP_CW'(RAMP_WIDTH))
           ? RAMP_CW'(RAMP_WIDTH) : stop_rd_q.offset[POS_W-1:POS_SHIFT];
    seg_cur = (s_q == '0) ? stop_rd_q.color : cur_q;
    for (int k = 0; k < 4; k++) begin
      seg_d[k] = $signed({1'b0, stop_rd_q.color[8*k +: 8]}) -
                 $signed({1'b0, seg_cur[8*k +: 8]});
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    valid_d      = valid_q;
    new_d        = new_q;
    j_d          = j_q;
    s_d          = s_q;
    idx_d        = idx_q;
    sp_d         = sp_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    acc_d        = acc_q;
    inc_d        = inc_q;
    pix_d        = pix_q;
    res_status_d = res_status_q;
    res_color_d  = res_color_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_color_d  = out_color_q;
    stop_we      = 1'b0;
    stop_wa      = j_q;
    stop_wd      = new_q;
    stop_ra      = s_q;
    ramp_we      = 1'b0;
    ramp_wa      = idx_q[RAMP_IW-1:0];
    ramp_wd      = nxt_q;
    ramp_ra      = pix_q;
    for (int k = 0; k < 4; k++) begin
      div_req[k].start = 1'b0;
      div_req[k].neg   = seg_d[k][8];
      div_req[k].mag   = DIV_W'(seg_d[k][8] ? -seg_d[k] : seg_d[k]) << FRAC_W;
      div_req[k].den   = RAMP_CW'(seg_sp - idx_q);
    end

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          res_status_d = 1'b0;
          res_color_d  = '0;
          case (cmd_e'(in_i.command))
            CMD_CLEAR: begin
              count_d = '0;
              valid_d = 1'b0;
              state_d = S_DONE;
            end
            CMD_ADD: begin
              new_d.offset = in_i.stop_position;
              new_d.color  = {a_in, premul(in_i.stop_blue, a_in),
                              premul(in_i.stop_green, a_in), premul(in_i.stop_red, a_in)};
              j_d = count_q[STOP_IW-1:0];
              if (count_q == STOP_CW'(MAX_STOPS)) begin
                res_status_d = 1'b1;
                state_d      = S_DONE;
              end else begin
                state_d = S_INS_CHK;
              end
            end
            CMD_READ: begin
              pix_d = in_i.pixel_index;
              if (valid_q) begin
                ramp_ra = in_i.pixel_index;
                state_d = S_RD_DATA;
              end else begin
                idx_d = '0;
                s_d   = '0;
                if (count_q == '0) begin
                  nxt_d   = '0;
                  state_d = S_RB_FILL;
                end else begin
                  state_d = S_RB_RD;
                end
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (j_q == '0) begin
          stop_we = 1'b1;
          count_d = count_q + 1'b1;
          valid_d = 1'b0;
          state_d = S_DONE;
        end else begin
          stop_ra = j_q - 1'b1;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        stop_we = 1'b1;
        if (stop_rd_q.offset > new_q.offset) begin
          stop_wd = stop_rd_q;
          j_d     = j_q - 1'b1;
          state_d = S_INS_CHK;
        end else begin
          count_d = count_q + 1'b1;
          valid_d = 1'b0;
          state_d = S_DONE;
        end
      end
      S_RB_RD: begin
        stop_ra = s_q;
        state_d = S_RB_SEG;
      end
      S_RB_SEG: begin
        nxt_d = stop_rd_q.color;
        cur_d = seg_cur;
        sp_d  = seg_sp;
        if (seg_sp > idx_q) begin
          for (int k = 0; k < 4; k++) begin
            div_req[k].start = 1'b1;
            acc_d[k] = $signed({2'b00, seg_cur[8*k +: 8], FRAC_W'(0)});
          end
          state_d = S_RB_DIV;
        end else begin
          state_d = S_RB_NEXT;
        end
      end
      S_RB_DIV: begin
        if (div_rsp[0].done) begin
          for (int k = 0; k < 4; k++) inc_d[k] = div_rsp[k].quot;
          state_d = S_RB_PIX;
        end
      end
      S_RB_PIX: begin
        ramp_we = 1'b1;
        ramp_wd = {clamp8(acc_q[3]), clamp8(acc_q[2]), clamp8(acc_q[1]), clamp8(acc_q[0])};
        for (int k = 0; k < 4; k++) acc_d[k] = acc_q[k] + inc_q[k];
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == sp_q) state_d = S_RB_NEXT;
      end
      S_RB_NEXT: begin
        if (idx_q == RAMP_CW'(RAMP_WIDTH)) begin
          ramp_we = 1'b1;
          ramp_wa = RAMP_IW'(RAMP_WIDTH - 1);
          valid_d = 1'b1;
          state_d = S_RD_ISSUE;
        end else begin
          cur_d = nxt_q;
          if ({1'b0, s_q} + 1'b1 == count_q) begin
            state_d = S_RB_FILL;
          end else begin
            s_d     = s_q + 1'b1;
            state_d = S_RB_RD;
          end
        end
      end
      S_RB_FILL: begin
        if (idx_q == RAMP_CW'(RAMP_WIDTH)) begin
          valid_d = 1'b1;
          state_d = S_RD_ISSUE;
        end else begin
          ramp_we = 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_RD_ISSUE: begin
        ramp_ra = pix_q;
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_color_d = ramp_rd_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_color_d  = res_color_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    j_q          <= j_d;
    s_q          <= s_d;
    idx_q        <= idx_d;
    sp_q         <= sp_d;
    cur_q        <= cur_d;
    nxt_q        <= nxt_d;
    acc_q        <= acc_d;
    inc_q        <= inc_d;
    pix_q        <= pix_d;
    res_status_q <= res_status_d;
    res_color_q  <= res_color_d;
    out_status_q <= out_status_d;
    out_color_q  <= out_color_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_red   = out_color_q[7:0];
  assign out_o.out_green = out_color_q[15:8];
  assign out_o.out_blue  = out_color_q[23:16];
  assign out_o.out_alpha = out_color_q[31:24];

  `GCRB_ASSERT(a_count_max, count_q <= STOP_CW'(MAX_STOPS))
  `GCRB_ASSERT(a_pix_in_seg, (state_q == S_RB_PIX) |-> (idx_q < sp_q))
  `GCRB_ASSERT(a_valid_rise, $rose(valid_q) |-> ($past(state_q) == S_RB_NEXT ||
                                                 $past(state_q) == S_RB_FILL))
  `GCRB_ASSERT_NEXT(a_done_load, (state_q == S_DONE && !out_valid_q), out_valid_q)

endmodule
`default_nettype wire

FILE: hdl/gcrb_div.sv
// Bit-serial signed divider for the per-pixel colour step.
`default_nettype none
module gcrb_div import gcrb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     n_q, n_d;
  logic [RAMP_CW-1:0]   rem_q, rem_d;
  logic [RAMP_CW-1:0]   den_q, den_d;
  logic                 neg_q, neg_d;
  logic [RAMP_CW:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    trial  = {rem_q, n_q[DIV_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = req_i.mag;
      rem_d  = '0;
      den_d  = req_i.den;
      neg_d  = req_i.neg;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = RAMP_CW'(trial - {1'b0, den_q});
        n_d   = {n_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[RAMP_CW-1:0];
        n_d   = {n_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed({2'b00, n_q}) : $signed({2'b00, n_q});

endmodule
`default_nettype wire

FILE: verif/gcrb_tb_if.sv
// Testbench package: the result beat type used by the scoreboard.
`timescale 1ns / 1ps
package gcrb_tb_pkg;
  import gcrb_pkg::*;

  typedef struct packed {
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_beat_t;
endpackage

FILE: verif/testbench.sv
// Testbench of the gradient colour ramp builder: random commands checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import gcrb_pkg::*;
  import gcrb_tb_pkg::*;

  class ramp_scoreboard;
    logic [16:0] offs[MAX_STOPS];
    logic [31:0] cols[MAX_STOPS];
    int          count;
    bit          ramp_ok;
    logic [31:0] ramp[RAMP_WIDTH];
    pixel_beat_t pending[$];
    int          errors;
    int          reads, adds, fulls;

    function new();
      count = 0;
      ramp_ok = 0;
      errors = 0;
    endfunction

    function void rebuild();
      int idx, sp, len, d, a, b;
      logic [31:0] cur, nxt, px;
      int acc[4], inc[4];
      bit ended;
      idx = 0;
      ended = 0;
      nxt = '0;
      for (int i = 0; i < RAMP_WIDTH; i++) ramp[i] = '0;
      ramp_ok = 1;
      if (count == 0) return;
      cur = cols[0];
      for (int s = 0; s < count; s++) begin
        nxt = cols[s];
        sp = (offs[s] * RAMP_WIDTH) >> 16;
        if (sp > RAMP_WIDTH) sp = RAMP_WIDTH;
        if (sp > idx) begin
          len = sp - idx;
          for (int k = 0; k < 4; k++) begin
            d = int'(nxt[8*k +: 8]) - int'(cur[8*k +: 8]);
            acc[k] = int'(cur[8*k +: 8]) * 65536;
            inc[k] = (d * 65536) / len;
          end
          for (; idx < sp; idx++) begin
            px = '0;
            for (int k = 0; k < 4; k++) begin
              a = acc[k] < 0 ? 0 : acc[k];
              b = a >>> 16;
              if (b > 255) b = 255;
              px[8*k +: 8] = b[7:0];
              acc[k] += inc[k];
            end
            ramp[idx] = px;
          end
        end
        if (idx >= RAMP_WIDTH) begin
          ramp[RAMP_WIDTH-1] = nxt;
          ended = 1;
          break;
        end
        cur = nxt;
      end
      if (!ended) for (; idx < RAMP_WIDTH; idx++) ramp[idx] = nxt;
    endfunction

    function void note_command(cmd_e cmd, logic [16:0] pos, logic [7:0] r, logic [7:0] g,
                               logic [7:0] bl, logic [7:0] al, logic [9:0] pi);
      pixel_beat_t e;
      int at;
      logic [31:0] c;
      e = '0;
      case (cmd)
        CMD_CLEAR: begin
          count = 0;
          ramp_ok = 0;
        end
        CMD_ADD: begin
          adds++;
          c = {al, 8'((bl * al) / 255), 8'((g * al) / 255), 8'((r * al) / 255)};
          if (count >= MAX_STOPS) begin
            e.status = 1;
            fulls++;
          end else begin
            at = 0;
            while (at < count && offs[at] <= pos) at++;
            for (int j = count; j > at; j--) begin
              offs[j] = offs[j-1];
              cols[j] = cols[j-1];
            end
            offs[at] = pos;
            cols[at] = c;
            count++;
            ramp_ok = 0;
          end
        end
        CMD_READ: begin
          reads++;
          if (!ramp_ok) rebuild();
          if (pi < RAMP_WIDTH) {e.alpha, e.blue, e.green, e.red} = ramp[pi];
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_beat(pixel_beat_t got);
      pixel_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.red !== e.red) begin
        $error("out_red exp %0d got %0d", e.red, got.red); errors++;
      end
      if (got.green !== e.green) begin
        $error("out_green exp %0d got %0d", e.green, got.green); errors++;
      end
      if (got.blue !== e.blue) begin
        $error("out_blue exp %0d got %0d", e.blue, got.blue); errors++;
      end
      if (got.alpha !== e.alpha) begin
        $error("out_alpha exp %0d got %0d", e.alpha, got.alpha); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  gcrb_in_if  cmd_ch();
  gcrb_out_if pix_ch();
  ramp_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;

  always #2 clk_i = ~clk_i;

  gradient_color_ramp_builder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch.sink), .out_o(pix_ch.source)
  );

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.command = CMD_CLEAR;
    cmd_ch.stop_position = '0;
    cmd_ch.stop_red = '0;
    cmd_ch.stop_green = '0;
    cmd_ch.stop_blue = '0;
    cmd_ch.stop_alpha = '0;
    cmd_ch.pixel_index = '0;
    pix_ch.ready = 0;
  end

  // receiver stall pattern, with calm stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: pix_ch.ready <= 1'b1;
      1: pix_ch.ready <= ($urandom_range(0, 3) != 0);
      default: pix_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_ch.valid && pix_ch.ready)
      sb.check_beat({pix_ch.status, pix_ch.out_red, pix_ch.out_green, pix_ch.out_blue,
                     pix_ch.out_alpha});
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(cmd_e cmd, logic [16:0] pos, logic [7:0] r, logic [7:0] g,
                      logic [7:0] b, logic [7:0] a, logic [9:0] pi);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.stop_position <= pos;
    cmd_ch.stop_red <= r;
    cmd_ch.stop_green <= g;
    cmd_ch.stop_blue <= b;
    cmd_ch.stop_alpha <= a;
    cmd_ch.pixel_index <= pi;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(cmd, pos, r, g, b, a, pi);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_item(int phase);
    int sel;
    logic [16:0] pos;
    sel = $urandom_range(0, 99);
    pos = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    if (sel < 5)
      send(CMD_CLEAR, 17'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           10'($urandom));
    else if (sel < 7)
      send(CMD_NONE, 17'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           10'($urandom));
    else if (sel < (phase ? 60 : 30))
      send(CMD_ADD, pos, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           10'($urandom));
    else
      send(CMD_READ, 17'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           10'($urandom));
  endtask

  initial begin
    int sent, burst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, edge reads, extremes
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd0);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd1023);
    send(CMD_NONE, '1, '1, '1, '1, '1, '1);
    send(CMD_ADD, 17'd0, 8'd255, 8'd0, 8'd128, 8'd255, '0);
    send(CMD_ADD, 17'd65536, 8'd0, 8'd255, 8'd77, 8'd128, '0);
    send(CMD_ADD, 17'd32768, 8'd10, 8'd20, 8'd30, 8'd0, '0);
    send(CMD_ADD, 17'd32768, 8'd200, 8'd100, 8'd50, 8'd200, '0);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd0);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd511);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd512);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd1023);
    send(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
    send(CMD_ADD, 17'h1FFFF, 8'd255, 8'd255, 8'd255, 8'd255, '0);
    send(CMD_ADD, 17'd20000, 8'd1, 8'd2, 8'd3, 8'd4, '0);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd3);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd1023);
    for (int i = 0; i < 16; i++)
      send(CMD_ADD, 17'($urandom_range(0, 65536)), 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), '0);
    send(CMD_READ, '0, '0, '0, '0, '0, 10'd700);
    drain();

    sent = 0;
    while (sent < 400) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) begin
        random_item((sent / 100) % 2);
        sent++;
      end
      if (sent > 200 && sent < 221) drain();
      else gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
    end
    drain();
    repeat (50) @(posedge clk_i);

    $display("covered %0d adds (%0d on full table) and %0d pixel reads",
             sb.adds, sb.fulls, sb.reads);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/gcrb_pkg.sv
hdl/gcrb_if.sv
hdl/gcrb_div.sv
hdl/gradient_color_ramp_builder_core.sv
verif/gcrb_tb_if.sv
verif/testbench.sv
